[rtl/core/ccmt_pkg.sv]
package ccmt_pkg;

  localparam int YEAR_BITS = 13;
  localparam int MODE_W    = 3;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int MS_W      = 10;

  // width of year / 4, used by the divisibility check
  localparam int QTR_W = YEAR_BITS - 2;

  localparam logic [MS_W-1:0]      MS_LAST    = MS_W'(999);
  localparam logic [SEC_W-1:0]     SEC_LAST   = SEC_W'(59);
  localparam logic [MIN_W-1:0]     MIN_LAST   = MIN_W'(59);
  localparam logic [HOUR_W-1:0]    HOUR_LAST  = HOUR_W'(23);
  localparam logic [MONTH_W-1:0]   MONTH_LAST = MONTH_W'(12);
  localparam logic [MONTH_W-1:0]   MONTH_FEB  = MONTH_W'(2);
  localparam logic [DAY_W-1:0]     DAY_FIRST  = DAY_W'(1);
  localparam logic [MONTH_W-1:0]   MONTH_FIRST = MONTH_W'(1);
  localparam logic [DAY_W-1:0]     LEN_31     = DAY_W'(31);
  localparam logic [DAY_W-1:0]     LEN_30     = DAY_W'(30);
  localparam logic [DAY_W-1:0]     LEN_29     = DAY_W'(29);
  localparam logic [DAY_W-1:0]     LEN_28     = DAY_W'(28);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK       = 3'd0,
    MODE_SET_ALL    = 3'd1,
    MODE_SET_YEAR   = 3'd2,
    MODE_SET_MONTH  = 3'd3,
    MODE_SET_DAY    = 3'd4,
    MODE_SET_HOUR   = 3'd5,
    MODE_SET_MINUTE = 3'd6,
    MODE_SET_SECOND = 3'd7
  } mode_t;

  // multiplicative inverse of an odd number modulo 2^32 (newton iteration)
  function automatic logic [31:0] inv_odd(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  // k divisible by 25 iff (k * inv25) mod 2^QTR_W <= (2^QTR_W - 1) / 25
  localparam logic [QTR_W-1:0] INV25 = QTR_W'(inv_odd(32'd25));
  localparam logic [QTR_W-1:0] LIM25 = QTR_W'(((1 << QTR_W) - 1) / 25);

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB:                      len = leap ? LEN_29 : LEN_28;
      4'd4, 4'd6, 4'd9, 4'd11:        len = LEN_30;
      default:                        len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/ccmt_in_if.sv]
interface ccmt_in_if;
  import ccmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [YEAR_BITS-1:0] set_year;
  logic [MONTH_W-1:0]   set_month;
  logic [DAY_W-1:0]     set_day;
  logic [HOUR_W-1:0]    set_hour;
  logic [MIN_W-1:0]     set_minute;
  logic [SEC_W-1:0]     set_second;

  modport source (
    output valid, mode, set_year, set_month, set_day, set_hour, set_minute,
           set_second,
    input  ready
  );

  modport sink (
    input  valid, mode, set_year, set_month, set_day, set_hour, set_minute,
           set_second,
    output ready
  );

endinterface

[rtl/core/ccmt_out_if.sv]
interface ccmt_out_if;
  import ccmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YEAR_BITS-1:0] year_now;
  logic [MONTH_W-1:0]   month_now;
  logic [DAY_W-1:0]     day_now;
  logic [HOUR_W-1:0]    hour_now;
  logic [MIN_W-1:0]     minute_now;
  logic [SEC_W-1:0]     second_now;
  logic [MS_W-1:0]      millisecond_now;
  logic                 is_leap_year;
  logic [DAY_W-1:0]     month_length;
  logic                 second_pulse;

  modport source (
    output valid, year_now, month_now, day_now, hour_now, minute_now,
           second_now, millisecond_now, is_leap_year, month_length,
           second_pulse,
    input  ready
  );

  modport sink (
    input  valid, year_now, month_now, day_now, hour_now, minute_now,
           second_now, millisecond_now, is_leap_year, month_length,
           second_pulse,
    output ready
  );

endinterface

[rtl/core/calendar_clock_millisecond_tick_top.sv]
// millisecond calendar clock
// in_ch carries one command word: a tick (advance one millisecond) or a set
// command (set all fields with the millisecond cleared, or set one field)
// out_ch returns one word per command: the full time after that command,
// the leap flag, the length of the current month and a second pulse
// a word accepted sits in the input register, and its result is loaded into
// the output register once that register is empty or being taken
// throughput: one word per cycle while out_ch takes results; the whole carry
// cascade and leap check fit between the input register and the output register
// the time counters themselves are the output register, so a result holds
// while the receiver stalls; the input register still takes one more word,
// then in_ch.ready drops until the output is taken
// reset (rst_n low, synchronous): January 1 of year 0, 00:00:00.000, leap
// flag set, month length 31, both registers empty
// set values beyond their range saturate, and a day beyond the new month's
// length is clamped to it
module calendar_clock_millisecond_tick_top (
  input  logic clk,
  input  logic rst_n,
  ccmt_in_if.sink    in_ch,
  ccmt_out_if.source out_ch
);
  import ccmt_pkg::*;

  // input register
  logic                 s1_valid_r;
  mode_t                s1_mode_r;
  logic [YEAR_BITS-1:0] s1_year_r;
  logic [MONTH_W-1:0]   s1_month_r;
  logic [DAY_W-1:0]     s1_day_r;
  logic [HOUR_W-1:0]    s1_hour_r;
  logic [MIN_W-1:0]     s1_min_r;
  logic [SEC_W-1:0]     s1_sec_r;

  // time state, doubles as the output register
  logic                 out_valid_r;
  logic [MS_W-1:0]      ms_r,    ms_nxt;
  logic [SEC_W-1:0]     sec_r,   sec_nxt;
  logic [MIN_W-1:0]     min_r,   min_nxt;
  logic [HOUR_W-1:0]    hour_r,  hour_nxt;
  logic [DAY_W-1:0]     day_r,   day_nxt;
  logic [MONTH_W-1:0]   mon_r,   mon_nxt;
  logic [YEAR_BITS-1:0] year_r,  year_nxt;
  logic                 leap_r,  leap_nxt;
  logic [DAY_W-1:0]     len_r,   len_nxt;
  logic                 pulse_r, pulse_nxt;

  logic                 s1_adv;
  logic                 in_take;
  logic                 is_set;
  logic [DAY_W-1:0]     day_pre;

  // carry chain
  logic c_ms, c_sec, c_min, c_hour, c_day, c_mon;

  // leap check
  logic [QTR_W-1:0]     qtr;
  logic [QTR_W-1:0]     qtr_prod;
  logic                 div4, div25;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign is_set = (s1_mode_r != MODE_TICK);

  assign c_ms   = (ms_r >= MS_LAST);
  assign c_sec  = c_ms   && (sec_r  >= SEC_LAST);
  assign c_min  = c_sec  && (min_r  >= MIN_LAST);
  assign c_hour = c_min  && (hour_r >= HOUR_LAST);
  assign c_day  = c_hour && (day_r  >= len_r);
  assign c_mon  = c_day  && (mon_r  >= MONTH_LAST);

  always_comb begin
    ms_nxt    = ms_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_pre   = day_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    pulse_nxt = 1'b0;
    unique case (s1_mode_r)
      MODE_TICK: begin
        ms_nxt    = c_ms ? '0 : ms_r + MS_W'(1);
        pulse_nxt = c_ms;
        if (c_ms) begin
          sec_nxt = c_sec ? '0 : sec_r + SEC_W'(1);
        end
        if (c_sec) begin
          min_nxt = c_min ? '0 : min_r + MIN_W'(1);
        end
        if (c_min) begin
          hour_nxt = c_hour ? '0 : hour_r + HOUR_W'(1);
        end
        if (c_hour) begin
          day_pre = c_day ? DAY_FIRST : day_r + DAY_W'(1);
        end
        if (c_day) begin
          mon_nxt = c_mon ? MONTH_FIRST : mon_r + MONTH_W'(1);
        end
        if (c_mon) begin
          // wraps to zero past the last year
          year_nxt = year_r + YEAR_BITS'(1);
        end
      end
      default: begin
        if (s1_mode_r == MODE_SET_ALL || s1_mode_r == MODE_SET_YEAR) begin
          year_nxt = s1_year_r;
        end
        if (s1_mode_r == MODE_SET_ALL || s1_mode_r == MODE_SET_MONTH) begin
          if (s1_month_r == '0) begin
            mon_nxt = MONTH_FIRST;
          end else if (s1_month_r > MONTH_LAST) begin
            mon_nxt = MONTH_LAST;
          end else begin
            mon_nxt = s1_month_r;
          end
        end
        if (s1_mode_r == MODE_SET_ALL || s1_mode_r == MODE_SET_DAY) begin
          day_pre = (s1_day_r == '0) ? DAY_FIRST : s1_day_r;
        end
        if (s1_mode_r == MODE_SET_ALL || s1_mode_r == MODE_SET_HOUR) begin
          hour_nxt = (s1_hour_r > HOUR_LAST) ? HOUR_LAST : s1_hour_r;
        end
        if (s1_mode_r == MODE_SET_ALL || s1_mode_r == MODE_SET_MINUTE) begin
          min_nxt = (s1_min_r > MIN_LAST) ? MIN_LAST : s1_min_r;
        end
        if (s1_mode_r == MODE_SET_ALL || s1_mode_r == MODE_SET_SECOND) begin
          sec_nxt = (s1_sec_r > SEC_LAST) ? SEC_LAST : s1_sec_r;
        end
        if (s1_mode_r == MODE_SET_ALL) begin
          ms_nxt = '0;
        end
      end
    endcase
  end

  // gregorian rule: year = 4k is leap unless k is a multiple of 25 but not of 100
  assign div4     = (year_nxt[1:0] == 2'b00);
  assign qtr      = year_nxt[YEAR_BITS-1:2];
  assign qtr_prod = QTR_W'(qtr * INV25);
  assign div25    = (qtr_prod <= LIM25);
  assign leap_nxt = div4 && (!div25 || (qtr[1:0] == 2'b00));
  assign len_nxt  = month_len(mon_nxt, leap_nxt);

  // a set can leave the day past the end of the month
  assign day_nxt = (is_set && (day_pre > len_nxt)) ? len_nxt : day_pre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ms_r        <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      day_r       <= DAY_FIRST;
      mon_r       <= MONTH_FIRST;
      year_r      <= '0;
      leap_r      <= 1'b1;
      len_r       <= LEN_31;
      pulse_r     <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        ms_r        <= ms_nxt;
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        hour_r      <= hour_nxt;
        day_r       <= day_nxt;
        mon_r       <= mon_nxt;
        year_r      <= year_nxt;
        leap_r      <= leap_nxt;
        len_r       <= len_nxt;
        pulse_r     <= pulse_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= mode_t'(in_ch.mode);
      s1_year_r  <= in_ch.set_year;
      s1_month_r <= in_ch.set_month;
      s1_day_r   <= in_ch.set_day;
      s1_hour_r  <= in_ch.set_hour;
      s1_min_r   <= in_ch.set_minute;
      s1_sec_r   <= in_ch.set_second;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.year_now        = year_r;
  assign out_ch.month_now       = mon_r;
  assign out_ch.day_now         = day_r;
  assign out_ch.hour_now        = hour_r;
  assign out_ch.minute_now      = min_r;
  assign out_ch.second_now      = sec_r;
  assign out_ch.millisecond_now = ms_r;
  assign out_ch.is_leap_year    = leap_r;
  assign out_ch.month_length    = len_r;
  assign out_ch.second_pulse    = pulse_r;

  // a second pulse only comes with the millisecond at zero
  a_pulse_ms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pulse_r |-> ms_r == '0)
    else $error("second pulse with nonzero millisecond");

  // day always within the current month
  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (day_r != '0) && (day_r <= len_r))
    else $error("day outside month");

  // february length follows the leap flag
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (mon_r == MONTH_FEB) |-> len_r == (leap_r ? LEN_29 : LEN_28))
    else $error("february length disagrees with leap flag");

  // a tick without rollover just counts the millisecond up
  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_mode_r == MODE_TICK) && (ms_r != MS_LAST)
    |=> (ms_r == $past(ms_r) + MS_W'(1)) && !pulse_r)
    else $error("tick did not advance millisecond");

endmodule

[sim/ccmt_clock_checker.sv]
module ccmt_clock_checker (
  input  logic clk,
  input  logic rst_n,
  ccmt_in_if   in_ch,
  ccmt_out_if  out_ch,
  output int   mismatches,
  output int   words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ccmt_pkg::*;

  localparam int YEAR_TOP = (1 << YEAR_BITS) - 1;

  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MIN_W-1:0]     minute;
    logic [SEC_W-1:0]     second;
    logic [MS_W-1:0]      msec;
    logic                 leap;
    logic [DAY_W-1:0]     mlen;
    logic                 pulse;
  } clock_state_t;

  clock_state_t clock_now;
  clock_state_t oldest;
  clock_state_t expected_times[$];
  int           errors;

  function automatic logic gregorian_leap(int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400 == 0);
  endfunction

  function automatic int days_in(int m, logic leap);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // state after one command word
  function automatic clock_state_t next_time(clock_state_t c, mode_t m, int sy, int smo,
                                             int sd, int sh, int smi, int ss);
    int           yr, mo, dy, hr, mi, se, ms, len;
    logic         leap;
    clock_state_t n;
    yr = int'(c.year);
    mo = int'(c.month);
    dy = int'(c.day);
    hr = int'(c.hour);
    mi = int'(c.minute);
    se = int'(c.second);
    ms = int'(c.msec);
    n  = c;
    n.pulse = 1'b0;
    if (m == MODE_TICK) begin
      ms++;
      if (ms >= 1000) begin
        ms = 0;
        n.pulse = 1'b1;
        se++;
      end
      if (se >= 60) begin
        se = 0;
        mi++;
      end
      if (mi >= 60) begin
        mi = 0;
        hr++;
      end
      if (hr >= 24) begin
        hr = 0;
        dy++;
      end
      // day carry uses the month length held before this tick
      if (dy > int'(c.mlen)) begin
        dy = 1;
        mo++;
      end
      if (mo > 12) begin
        mo = 1;
        yr = (yr >= YEAR_TOP) ? 0 : yr + 1;
      end
    end else begin
      if (m inside {MODE_SET_ALL, MODE_SET_YEAR}) yr = (sy > YEAR_TOP) ? YEAR_TOP : sy;
      if (m inside {MODE_SET_ALL, MODE_SET_MONTH}) mo = (smo < 1) ? 1 : (smo > 12) ? 12 : smo;
      if (m inside {MODE_SET_ALL, MODE_SET_DAY}) dy = (sd < 1) ? 1 : (sd > 31) ? 31 : sd;
      if (m inside {MODE_SET_ALL, MODE_SET_HOUR}) hr = (sh > 23) ? 23 : sh;
      if (m inside {MODE_SET_ALL, MODE_SET_MINUTE}) mi = (smi > 59) ? 59 : smi;
      if (m inside {MODE_SET_ALL, MODE_SET_SECOND}) se = (ss > 59) ? 59 : ss;
      if (m == MODE_SET_ALL) ms = 0;
    end
    leap = gregorian_leap(yr);
    len  = days_in(mo, leap);
    if (m != MODE_TICK && dy > len) dy = len;
    n.year   = YEAR_BITS'(yr);
    n.month  = MONTH_W'(mo);
    n.day    = DAY_W'(dy);
    n.hour   = HOUR_W'(hr);
    n.minute = MIN_W'(mi);
    n.second = SEC_W'(se);
    n.msec   = MS_W'(ms);
    n.leap   = leap;
    n.mlen   = DAY_W'(len);
    return n;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_now      = '0;
      clock_now.day   = DAY_W'(1);
      clock_now.month = MONTH_W'(1);
      clock_now.leap  = 1'b1;
      clock_now.mlen  = DAY_W'(31);
      expected_times.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_times.size() == 0) begin
          $error("result word with no command word waiting for it");
          errors++;
        end else begin
          oldest = expected_times.pop_front();
          check_field("year_now", int'(oldest.year), int'(out_ch.year_now));
          check_field("month_now", int'(oldest.month), int'(out_ch.month_now));
          check_field("day_now", int'(oldest.day), int'(out_ch.day_now));
          check_field("hour_now", int'(oldest.hour), int'(out_ch.hour_now));
          check_field("minute_now", int'(oldest.minute), int'(out_ch.minute_now));
          check_field("second_now", int'(oldest.second), int'(out_ch.second_now));
          check_field("millisecond_now", int'(oldest.msec),
                      int'(out_ch.millisecond_now));
          check_field("is_leap_year", int'(oldest.leap), int'(out_ch.is_leap_year));
          check_field("month_length", int'(oldest.mlen), int'(out_ch.month_length));
          check_field("second_pulse", int'(oldest.pulse), int'(out_ch.second_pulse));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        clock_now = next_time(clock_now, mode_t'(in_ch.mode), int'(in_ch.set_year),
                              int'(in_ch.set_month), int'(in_ch.set_day),
                              int'(in_ch.set_hour), int'(in_ch.set_minute),
                              int'(in_ch.set_second));
        expected_times.push_back(clock_now);
      end
    end
    mismatches    <= errors;
    words_pending <= expected_times.size();
  end

endmodule

[sim/calendar_clock_millisecond_tick_top_tb.sv]
module calendar_clock_millisecond_tick_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccmt_pkg::*;

  // stimulus sizing
  localparam int TOTAL_WORDS   = 1550;
  localparam int SET_MIX_WORDS = 300;   // set-heavy stretch before the long tick run
  localparam int WAIT_MAX      = 12;
  localparam int RX_HOLD_AT    = 400;   // result count at which the receiver stalls long
  localparam int RX_HOLD_LEN   = 200;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES   = 4;
  localparam int YEAR_TOP      = (1 << YEAR_BITS) - 1;

  logic clk = 1'b0;
  logic rst_n;

  ccmt_in_if  in_ch ();
  ccmt_out_if out_ch ();

  int mismatches;
  int words_pending;

  // sender bookkeeping: ms_pos mirrors the millisecond counter so the
  // stimulus knows when the next tick carries into the second
  int items_sent;
  int ms_pos;
  int rollovers;
  bit tx_burst;
  bit rx_burst;
  int idle_cycles;

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  calendar_clock_millisecond_tick_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ccmt_clock_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  // field value biased toward the all-zero and all-one ends
  function automatic int pick_value(int bits);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return (1 << bits) - 1;
      default: return $urandom_range(0, (1 << bits) - 1);
    endcase
  endfunction

  // years that hit each branch of the leap rule
  function automatic int pick_year();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 20) * 400;
      1:       return $urandom_range(1, 81) * 100;
      2:       return $urandom_range(0, YEAR_TOP / 4) * 4;
      default: return pick_value(YEAR_BITS);
    endcase
  endfunction

  // one command word: random gap, then hold valid until accepted
  task automatic send_word(mode_t m, int y, int mo, int d, int h, int mi, int s);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, WAIT_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.set_year   <= YEAR_BITS'(y);
    in_ch.set_month  <= MONTH_W'(mo);
    in_ch.set_day    <= DAY_W'(d);
    in_ch.set_hour   <= HOUR_W'(h);
    in_ch.set_minute <= MIN_W'(mi);
    in_ch.set_second <= SEC_W'(s);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (m == MODE_TICK) ms_pos = (ms_pos + 1) % 1000;
    else if (m == MODE_SET_ALL) ms_pos = 0;
  endtask

  // tick with junk in the unused set fields
  task automatic send_tick();
    send_word(MODE_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // single-field set; the other fields carry junk the block must ignore
  task automatic set_field(mode_t m, int v);
    int y, mo, d, h, mi, s;
    y  = $urandom;
    mo = $urandom;
    d  = $urandom;
    h  = $urandom;
    mi = $urandom;
    s  = $urandom;
    case (m)
      MODE_SET_YEAR:   y  = v;
      MODE_SET_MONTH:  mo = v;
      MODE_SET_DAY:    d  = v;
      MODE_SET_HOUR:   h  = v;
      MODE_SET_MINUTE: mi = v;
      MODE_SET_SECOND: s  = v;
      default: ;
    endcase
    send_word(m, y, mo, d, h, mi, s);
  endtask

  task automatic send_random_set();
    mode_t m;
    int    v;
    m = mode_t'($urandom_range(MODE_SET_YEAR, MODE_SET_SECOND));
    case (m)
      MODE_SET_YEAR:  v = pick_year();
      MODE_SET_MONTH: v = pick_value(MONTH_W);
      MODE_SET_DAY:   v = pick_value(DAY_W);
      MODE_SET_HOUR:  v = pick_value(HOUR_W);
      default:        v = pick_value(SEC_W);
    endcase
    set_field(m, v);
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // result side: random stall per word, one long stall to back the block up
  initial begin : result_drain
    int w, taken;
    taken = 0;
    rx_burst = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      w = rx_burst ? 0 : $urandom_range(0, WAIT_MAX);
      // long hold-off while the sender keeps offering, so in_ch.ready drops
      if (taken == RX_HOLD_AT) w = RX_HOLD_LEN;
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("calendar_clock_millisecond_tick_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int r, y, mo;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_TICK;
    in_ch.set_year   <= '0;
    in_ch.set_month  <= '0;
    in_ch.set_day    <= '0;
    in_ch.set_hour   <= '0;
    in_ch.set_minute <= '0;
    in_ch.set_second <= '0;
    rst_n            <= 1'b0;
    items_sent = 0;
    ms_pos     = 0;
    rollovers  = 0;
    tx_burst   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick out of reset (year 0 is leap, january)
    send_tick();
    // set all at the low end: month and day of zero saturate to one
    send_word(MODE_SET_ALL, 0, 0, 0, 0, 0, 0);
    // set all at the high end: every field saturates, odd top year is common
    send_word(MODE_SET_ALL, YEAR_TOP, 15, 31, 31, 63, 63);
    // february 29 in a common century year clamps to 28
    send_word(MODE_SET_ALL, 1900, 2, 29, 12, 30, 30);
    // february in a 400-year leap year, day 31 clamps to 29
    send_word(MODE_SET_ALL, 2000, 2, 31, 0, 0, 0);
    send_word(MODE_SET_ALL, 2024, 2, 30, 7, 8, 9);
    send_word(MODE_SET_ALL, 2023, 2, 29, 1, 2, 3);
    // day clamped under a kept month, then month changed under a kept day
    set_field(MODE_SET_DAY, 31);
    set_field(MODE_SET_MONTH, 4);
    set_field(MODE_SET_DAY, 31);
    set_field(MODE_SET_MONTH, 2);
    // year changed under a kept february day
    set_field(MODE_SET_YEAR, 2024);
    set_field(MODE_SET_DAY, 31);
    set_field(MODE_SET_YEAR, 2023);
    set_field(MODE_SET_YEAR, 100);
    set_field(MODE_SET_YEAR, 400);
    // single fields past their range saturate
    set_field(MODE_SET_HOUR, 31);
    set_field(MODE_SET_MINUTE, 63);
    set_field(MODE_SET_SECOND, 63);
    set_field(MODE_SET_MONTH, 0);
    set_field(MODE_SET_MONTH, 15);
    set_field(MODE_SET_DAY, 0);
    set_field(MODE_SET_YEAR, YEAR_TOP);
    send_tick();
    send_tick();
    drain();

    // set-heavy mix: clamping and the leap rule over many dates
    repeat (SET_MIX_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_word(MODE_SET_ALL, pick_year(), pick_value(MONTH_W), pick_value(DAY_W),
                  pick_value(HOUR_W), pick_value(MIN_W), pick_value(SEC_W));
      end else if (r < 75) begin
        send_random_set();
      end else begin
        send_tick();
      end
    end
    drain();

    // tick-heavy run: no set all here, so the milliseconds keep counting up;
    // just before a carry into the second, line up the carry cascade
    while (items_sent < TOTAL_WORDS || rollovers == 0) begin
      if (ms_pos == 999) begin
        if (rollovers == 0) begin
          // full cascade: december 31 of the top year wraps to year 0
          y  = YEAR_TOP;
          mo = 12;
        end else begin
          case ($urandom_range(0, 2))
            0:       begin y = 1900; mo = 2; end
            1:       begin y = 2024; mo = 2; end
            default: begin y = pick_year(); mo = $urandom_range(1, 12); end
          endcase
        end
        set_field(MODE_SET_YEAR, y);
        set_field(MODE_SET_MONTH, mo);
        set_field(MODE_SET_DAY, 31);
        set_field(MODE_SET_HOUR, 23);
        set_field(MODE_SET_MINUTE, 59);
        set_field(MODE_SET_SECOND, 59);
        send_tick();
        rollovers++;
      end else if ($urandom_range(0, 9) != 0) begin
        send_tick();
      end else begin
        send_random_set();
      end
    end

    // wait out the last results, then the pipeline tail
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("calendar_clock_millisecond_tick_top_tb passed");
    end else begin
      $display("calendar_clock_millisecond_tick_top_tb failed");
    end
    $finish;
  end

endmodule
